// ===== design/icjd_pkg.sv =====
`timescale 1ns / 1ps

package icjd_pkg;

  localparam int MASK_W      = 16;
  localparam int MAX_UNITS   = 16;
  localparam int JOB_SLOTS   = 32;
  localparam int SLOT_W      = 5;
  localparam int UC_W        = 5;
  localparam int CNT_W       = 5;
  localparam int MAX_RESULTS = 16;
  localparam int KW          = $clog2(MAX_RESULTS + 1);

  typedef logic [1:0] op_t;
  localparam op_t OP_SUBMIT = 2'd0;
  localparam op_t OP_FINISH = 2'd1;
  localparam op_t OP_TICK   = 2'd2;

  typedef logic [2:0] status_t;
  localparam status_t ST_QUEUED     = 3'd0;
  localparam status_t ST_REJECTED   = 3'd1;
  localparam status_t ST_DISPATCHED = 3'd2;
  localparam status_t ST_NONE       = 3'd3;
  localparam status_t ST_FINISHED   = 3'd4;
  localparam status_t ST_UNKNOWN    = 3'd5;

  typedef struct packed {
    op_t               op;
    logic [MASK_W-1:0] mask;
    logic [SLOT_W-1:0] job;
    logic              failed;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] job;
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] busy;
    logic [CNT_W-1:0]  pending;
    logic              last;
  } result_t;

  typedef struct packed {
    logic push;
    cmd_t data;
  } cmd_push_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUBMIT,
    S_FIN_READ,
    S_FIN_DONE,
    S_TICK_QREAD,
    S_TICK_MREAD,
    S_TICK_CHECK,
    S_TICK_END
  } back_state_t;

endpackage

// ===== design/icjd_front.sv =====
`timescale 1ns / 1ps

module icjd_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [icjd_pkg::UC_W-1:0]        cfg_wr_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  icjd_pkg::op_t                    operation,
  input  logic [icjd_pkg::MASK_W-1:0]      unit_mask,
  input  logic                             use_all,
  input  logic [icjd_pkg::SLOT_W-1:0]      job_number,
  input  logic                             failed,
  input  logic                             cmd_full,
  output icjd_pkg::cmd_push_t              cmd_push
);

  logic [icjd_pkg::UC_W-1:0]   unit_count;
  logic [icjd_pkg::MASK_W-1:0] present;
  logic                        known_op;

  // present-unit mask, count saturated to 1..MAX_UNITS
  function automatic logic [icjd_pkg::MASK_W-1:0] present_units(
    input logic [icjd_pkg::UC_W-1:0] n
  );
    logic [icjd_pkg::UC_W-1:0]   c;
    logic [icjd_pkg::MASK_W:0]   wide;
    c = n;
    if (c == '0) c = icjd_pkg::UC_W'(1);
    if (c > icjd_pkg::UC_W'(icjd_pkg::MAX_UNITS)) c = icjd_pkg::UC_W'(icjd_pkg::MAX_UNITS);
    wide = ((icjd_pkg::MASK_W + 1)'(1) << c) - (icjd_pkg::MASK_W + 1)'(1);
    return wide[icjd_pkg::MASK_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_count <= icjd_pkg::UC_W'(16);
    end else if (cfg_wr_en) begin
      unit_count <= cfg_wr_data;
    end
  end

  assign present  = present_units(unit_count);
  assign known_op = (operation == icjd_pkg::OP_SUBMIT) ||
                    (operation == icjd_pkg::OP_FINISH) ||
                    (operation == icjd_pkg::OP_TICK);

  assign req_stall = cmd_full;

  // unused op code is dropped here and never reaches the back end
  always_comb begin
    cmd_push.push        = req_valid && !cmd_full && known_op;
    cmd_push.data.op     = operation;
    cmd_push.data.mask   = use_all ? present : (unit_mask & present);
    cmd_push.data.job    = job_number;
    cmd_push.data.failed = failed;
  end

endmodule

// ===== design/icjd_cmd_fifo.sv =====
`timescale 1ns / 1ps

module icjd_cmd_fifo (
  input  logic                clk,
  input  logic                rst,
  input  icjd_pkg::cmd_push_t cmd_push,
  output logic                full,
  input  logic                pop,
  output icjd_pkg::cmd_t      pop_data,
  output logic                empty
);

  icjd_pkg::cmd_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (cmd_push.push) begin
      entries[wr_ptr] <= cmd_push.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (cmd_push.push) wr_ptr <= ~wr_ptr;
      if (pop)           rd_ptr <= ~rd_ptr;
      case ({cmd_push.push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/icjd_back.sv =====
`timescale 1ns / 1ps

module icjd_back #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_empty,
  input  icjd_pkg::cmd_t      cmd_data,
  output logic                cmd_pop,
  output logic                res_valid,
  input  logic                res_stall,
  output icjd_pkg::result_t   res
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);

  icjd_pkg::back_state_t state, state_next;

  logic [icjd_pkg::SLOT_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [icjd_pkg::MASK_W-1:0] slot_mem  [icjd_pkg::JOB_SLOTS];
  logic [icjd_pkg::SLOT_W-1:0] q_rdata;
  logic [icjd_pkg::MASK_W-1:0] m_rdata;
  logic [icjd_pkg::SLOT_W-1:0] m_raddr;

  logic [QW-1:0]                  head;
  logic [FW-1:0]                  fill;
  logic [icjd_pkg::MASK_W-1:0]    busy;
  logic [icjd_pkg::SLOT_W-1:0]    next_num;
  logic [icjd_pkg::JOB_SLOTS-1:0] in_use;
  logic [icjd_pkg::JOB_SLOTS-1:0] active;
  logic [31:0]                    done_count;
  logic [31:0]                    fail_count;
  logic [icjd_pkg::KW-1:0]        disp_cnt;
  icjd_pkg::cmd_t                 cur;
  logic [icjd_pkg::SLOT_W-1:0]    cur_job;
  icjd_pkg::result_t              stage;
  logic                           stage_valid;

  logic          out_free;
  logic          queue_full;
  logic          sub_ok;
  logic          blocked;
  logic          tick_stop;
  logic [QW:0]   tail_sum;
  logic [QW-1:0] tail;
  logic [QW-1:0] head_inc;
  logic          do_submit;
  logic          do_finish;
  logic          do_disp;
  logic          do_end;
  logic          load_out;

  assign out_free   = !res_valid || !res_stall;
  assign queue_full = (fill == FW'(QUEUE_DEPTH));
  assign sub_ok     = !queue_full && !in_use[next_num];
  assign blocked    = (m_rdata & busy) != '0;
  assign tick_stop  = (fill == '0) || (disp_cnt == icjd_pkg::KW'(icjd_pkg::MAX_RESULTS));
  assign tail_sum   = {1'b0, head} + (QW + 1)'(fill);
  assign tail       = (tail_sum >= (QW + 1)'(QUEUE_DEPTH)) ?
                      QW'(tail_sum - (QW + 1)'(QUEUE_DEPTH)) : tail_sum[QW-1:0];
  assign head_inc   = (head == QW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      icjd_pkg::S_IDLE: begin
        if (!cmd_empty) begin
          case (cmd_data.op)
            icjd_pkg::OP_SUBMIT: state_next = icjd_pkg::S_SUBMIT;
            icjd_pkg::OP_FINISH: state_next = icjd_pkg::S_FIN_READ;
            icjd_pkg::OP_TICK:   state_next = icjd_pkg::S_TICK_QREAD;
            default:             state_next = icjd_pkg::S_IDLE;
          endcase
        end
      end
      icjd_pkg::S_SUBMIT:   if (out_free) state_next = icjd_pkg::S_IDLE;
      icjd_pkg::S_FIN_READ: state_next = icjd_pkg::S_FIN_DONE;
      icjd_pkg::S_FIN_DONE: if (out_free) state_next = icjd_pkg::S_IDLE;
      icjd_pkg::S_TICK_QREAD: begin
        state_next = tick_stop ? icjd_pkg::S_TICK_END : icjd_pkg::S_TICK_MREAD;
      end
      icjd_pkg::S_TICK_MREAD: state_next = icjd_pkg::S_TICK_CHECK;
      icjd_pkg::S_TICK_CHECK: begin
        if (blocked) state_next = icjd_pkg::S_TICK_END;
        else if (!stage_valid || out_free) state_next = icjd_pkg::S_TICK_QREAD;
      end
      icjd_pkg::S_TICK_END: if (out_free) state_next = icjd_pkg::S_IDLE;
      default: state_next = icjd_pkg::S_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    cmd_pop   = 1'b0;
    do_submit = 1'b0;
    do_finish = 1'b0;
    do_disp   = 1'b0;
    do_end    = 1'b0;
    m_raddr   = cur_job;
    case (state)
      icjd_pkg::S_IDLE:       cmd_pop   = !cmd_empty;
      icjd_pkg::S_SUBMIT:     do_submit = out_free;
      icjd_pkg::S_FIN_DONE:   do_finish = out_free;
      icjd_pkg::S_TICK_MREAD: m_raddr   = q_rdata;
      icjd_pkg::S_TICK_CHECK: do_disp   = !blocked && (!stage_valid || out_free);
      icjd_pkg::S_TICK_END:   do_end    = out_free;
      default:                cmd_pop   = 1'b0;
    endcase
    load_out = do_submit || do_finish || do_end || (do_disp && stage_valid);
  end

  // queue and slot memories
  always_ff @(posedge clk) begin
    if (do_submit && sub_ok) begin
      queue_mem[tail]    <= next_num;
      slot_mem[next_num] <= cur.mask;
    end
    q_rdata <= queue_mem[head];
    m_rdata <= slot_mem[m_raddr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur     <= cmd_data;
      cur_job <= cmd_data.job;
    end
    if (state == icjd_pkg::S_TICK_MREAD) cur_job <= q_rdata;
    if (do_disp) begin
      stage.status  <= icjd_pkg::ST_DISPATCHED;
      stage.job     <= cur_job;
      stage.mask    <= m_rdata;
      stage.busy    <= busy | m_rdata;
      stage.pending <= icjd_pkg::CNT_W'(fill - 1'b1);
      stage.last    <= 1'b0;
    end
    if (do_submit) begin
      res.status  <= sub_ok ? icjd_pkg::ST_QUEUED : icjd_pkg::ST_REJECTED;
      res.job     <= next_num;
      res.mask    <= cur.mask;
      res.busy    <= busy;
      res.pending <= sub_ok ? icjd_pkg::CNT_W'(fill + 1'b1) : icjd_pkg::CNT_W'(fill);
      res.last    <= 1'b1;
    end else if (do_finish) begin
      res.status  <= active[cur_job] ? icjd_pkg::ST_FINISHED : icjd_pkg::ST_UNKNOWN;
      res.job     <= cur_job;
      res.mask    <= active[cur_job] ? m_rdata : '0;
      res.busy    <= active[cur_job] ? (busy & ~m_rdata) : busy;
      res.pending <= icjd_pkg::CNT_W'(fill);
      res.last    <= 1'b1;
    end else if (do_end) begin
      if (stage_valid) begin
        res.status  <= stage.status;
        res.job     <= stage.job;
        res.mask    <= stage.mask;
        res.busy    <= stage.busy;
        res.pending <= stage.pending;
        res.last    <= 1'b1;
      end else begin
        res.status  <= icjd_pkg::ST_NONE;
        res.job     <= '0;
        res.mask    <= '0;
        res.busy    <= busy;
        res.pending <= icjd_pkg::CNT_W'(fill);
        res.last    <= 1'b1;
      end
    end else if (do_disp && stage_valid) begin
      res <= stage;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= icjd_pkg::S_IDLE;
      head        <= '0;
      fill        <= '0;
      busy        <= '0;
      next_num    <= '0;
      in_use      <= '0;
      active      <= '0;
      done_count  <= '0;
      fail_count  <= '0;
      disp_cnt    <= '0;
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) disp_cnt <= '0;
      if (do_submit && sub_ok) begin
        in_use[next_num] <= 1'b1;
        active[next_num] <= 1'b0;
        fill             <= fill + 1'b1;
        next_num         <= next_num + 1'b1;
      end
      if (do_finish && active[cur_job]) begin
        busy            <= busy & ~m_rdata;
        active[cur_job] <= 1'b0;
        in_use[cur_job] <= 1'b0;
        if (cur.failed) fail_count <= fail_count + 32'd1;
        else            done_count <= done_count + 32'd1;
      end
      if (do_disp) begin
        busy            <= busy | m_rdata;
        head            <= head_inc;
        fill            <= fill - 1'b1;
        active[cur_job] <= 1'b1;
        disp_cnt        <= disp_cnt + 1'b1;
        stage_valid     <= 1'b1;
      end
      if (do_end) stage_valid <= 1'b0;
      if (load_out)       res_valid <= 1'b1;
      else if (!res_stall) res_valid <= 1'b0;
    end
  end

endmodule

// ===== design/in_order_chiplet_job_dispatcher.sv =====
`timescale 1ns / 1ps

// channel   signals                                    moves
// -------   ----------------------------------------   ------------------------------
// cfg       cfg_wr_en, cfg_wr_data                     unit_count write, no wait
// req       req_valid, req_stall, operation..failed    one request: submit/finish/tick
// res       res_valid, res_stall, status..last         one result, last marks the end
//
// a request passes the front stage into a two-entry command queue
// back end steps: submit in S_SUBMIT, finish in S_FIN_READ then S_FIN_DONE, tick per job in
// S_TICK_QREAD, S_TICK_MREAD, S_TICK_CHECK, closing in S_TICK_END (also on a blocked job),
// set by the queue and slot memory reads that go one after another
// rst is synchronous: queue empty, all units idle, all slots free, unit_count 16
// req_stall rises only while the command queue holds two requests
// res_stall holds the result register; the back end waits on it, the front keeps taking until the command queue is full

module in_order_chiplet_job_dispatcher #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [icjd_pkg::UC_W-1:0]    cfg_wr_data,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic [1:0]                   operation,
  input  logic [icjd_pkg::MASK_W-1:0]  unit_mask,
  input  logic                         use_all,
  input  logic [icjd_pkg::SLOT_W-1:0]  job_number,
  input  logic                         failed,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [2:0]                   status,
  output logic [icjd_pkg::SLOT_W-1:0]  result_job,
  output logic [icjd_pkg::MASK_W-1:0]  result_mask,
  output logic [icjd_pkg::MASK_W-1:0]  busy_units,
  output logic [icjd_pkg::CNT_W-1:0]   pending_count,
  output logic                         last
);

  icjd_pkg::cmd_push_t cmd_push;
  icjd_pkg::cmd_t      cmd_data;
  icjd_pkg::result_t   res;
  logic                cmd_full;
  logic                cmd_empty;
  logic                cmd_pop;

  // front: holds unit_count, masks the job to present units, drops unused op code
  icjd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .operation   (operation),
    .unit_mask   (unit_mask),
    .use_all     (use_all),
    .job_number  (job_number),
    .failed      (failed),
    .cmd_full    (cmd_full),
    .cmd_push    (cmd_push)
  );

  // short queue so the front keeps accepting while the back end is busy
  icjd_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .cmd_push (cmd_push),
    .full     (cmd_full),
    .pop      (cmd_pop),
    .pop_data (cmd_data),
    .empty    (cmd_empty)
  );

  // back: job queue, slot table, busy mask and the result register
  icjd_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data),
    .cmd_pop   (cmd_pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign status        = res.status;
  assign result_job    = res.job;
  assign result_mask   = res.mask;
  assign busy_units    = res.busy;
  assign pending_count = res.pending;
  assign last          = res.last;

  // a dispatched job's units are all busy afterwards
  a_disp_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == icjd_pkg::ST_DISPATCHED |-> (result_mask & ~busy_units) == '0)
    else $error("dispatched units not marked busy");

  // a finished job's units are all free afterwards
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == icjd_pkg::ST_FINISHED |-> (result_mask & busy_units) == '0)
    else $error("finished units still busy");

  // only a tick produces more than one result
  a_multi_tick: assert property (@(posedge clk) disable iff (rst)
    res_valid && !last |-> status == icjd_pkg::ST_DISPATCHED)
    else $error("non-final result that is not a dispatch");

endmodule
